>>> rtl/core/mcab_pkg.sv
// ----------------------------------------------------------------------------
// mcab_pkg
// Shared constants, register map, types and the alignment function of the
// multi-channel aligned bump allocator.
// ----------------------------------------------------------------------------
package mcab_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_CHANNELS = 4;
    localparam int GRID_MAX     = 8;

    // Request queue between front and back
    localparam int QUEUE_DEPTH  = 2;

    // Field widths
    localparam int ADDR_W  = 32;
    localparam int BYTES_W = 32;
    localparam int GRID_W  = 4;
    localparam int CHAN_W  = 2;
    localparam int CCNT_W  = 3;
    localparam int WIN_W   = 64;

    // APB side
    localparam int PADDR_W = 6;
    localparam int PDATA_W = 64;

    // Register indexes (byte address = 8 * index)
    localparam logic [2:0] REG_ALIGN_MODE    = 3'd0;
    localparam logic [2:0] REG_CHANNEL_COUNT = 3'd1;
    localparam logic [2:0] REG_REGION0       = 3'd2;

    // Alignment modes
    localparam logic ALIGN_ODD32 = 1'b0;
    localparam logic ALIGN_64    = 1'b1;

    // Static configuration seen by the back end
    typedef struct packed {
        logic              align_mode;
        logic [CCNT_W-1:0] channel_count;
    } t_cfg;

    // Round a 32-bit address up to the alignment; result needs 33 bits.
    // Odd-32 mode: ceil(a/32) forced odd, which equals the round-up plus
    // an extra 32 when the rounded value sits on a 64-byte boundary.
    function automatic logic [ADDR_W:0] align_addr(input logic mode,
                                                   input logic [ADDR_W-1:0] a);
        logic [ADDR_W-5:0] t32;
        logic [ADDR_W-6:0] t64;
        t32 = {1'b0, a[ADDR_W-1:5]} + (ADDR_W-4)'(|a[4:0]);
        t64 = {1'b0, a[ADDR_W-1:6]} + (ADDR_W-5)'(|a[5:0]);
        if (mode == ALIGN_64) begin
            return {t64, 6'b0};
        end
        return {t32 | (ADDR_W-4)'(1), 5'b0};
    endfunction

endpackage

>>> rtl/core/mcab_queue.sv
// ----------------------------------------------------------------------------
// mcab_queue
// Small register FIFO holding classified requests between front and back.
// ----------------------------------------------------------------------------
module mcab_queue #(
    parameter int WIDTH = 39,
    parameter int DEPTH = mcab_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             push_ok, pop_ok;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (push_ok) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(r_wr + 1'b1);
        end
        if (pop_ok) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(r_rd + 1'b1);
        end
        if (push_ok && !pop_ok) begin
            n_cnt = CNT_W'(r_cnt + 1'b1);
        end else if (pop_ok && !push_ok) begin
            n_cnt = CNT_W'(r_cnt - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

>>> rtl/core/mcab_front.sv
// ----------------------------------------------------------------------------
// mcab_front
// Request intake: clamps the grid, counts cells, drops empty grids and
// pushes the rest into the request queue.
// ----------------------------------------------------------------------------
module mcab_front #(
    parameter int GRID_MAX = mcab_pkg::GRID_MAX,
    parameter int CELL_W   = 7
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_busy,
    input  logic [mcab_pkg::BYTES_W-1:0] i_buffer_bytes,
    input  logic [mcab_pkg::GRID_W-1:0]  i_grid_rows,
    input  logic [mcab_pkg::GRID_W-1:0]  i_grid_cols,
    output logic                         o_push,
    output logic [mcab_pkg::BYTES_W-1:0] o_bytes,
    output logic [CELL_W-1:0]            o_cells,
    input  logic                         i_q_full
);
    localparam logic [mcab_pkg::GRID_W-1:0] GMAX = mcab_pkg::GRID_W'(GRID_MAX);

    logic                          r_valid;
    logic [mcab_pkg::BYTES_W-1:0]  r_bytes;
    logic [CELL_W-1:0]             r_cells;
    logic [mcab_pkg::GRID_W-1:0]   rows_c, cols_c;
    logic [2*mcab_pkg::GRID_W-1:0] prod;
    logic                          take, drain;

    assign rows_c = (i_grid_rows > GMAX) ? GMAX : i_grid_rows;
    assign cols_c = (i_grid_cols > GMAX) ? GMAX : i_grid_cols;
    assign prod   = rows_c * cols_c;

    // holding stage drains when the queue has room
    assign drain  = r_valid && !i_q_full;
    assign o_busy = r_valid && i_q_full;
    assign take   = i_start && !o_busy;

    assign o_push  = drain && (r_cells != '0);
    assign o_bytes = r_bytes;
    assign o_cells = r_cells;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (drain) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_bytes <= i_buffer_bytes;
            r_cells <= CELL_W'(prod);
        end
    end

endmodule

>>> rtl/core/mcab_back.sv
// ----------------------------------------------------------------------------
// mcab_back
// Placement engine: walks the cells of one request, aligns the bump
// pointer, tests the fit and moves across channels; drives the results.
// ----------------------------------------------------------------------------
module mcab_back #(
    parameter int MAX_CHANNELS = mcab_pkg::MAX_CHANNELS,
    parameter int CELL_W       = 7
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  mcab_pkg::t_cfg               i_cfg,
    input  logic [mcab_pkg::WIN_W-1:0]   i_win [MAX_CHANNELS],
    input  logic                         i_q_empty,
    input  logic [mcab_pkg::BYTES_W-1:0] i_q_bytes,
    input  logic [CELL_W-1:0]            i_q_cells,
    output logic                         o_pop,
    output logic                         o_result_valid,
    output logic [mcab_pkg::CHAN_W-1:0]  o_channel_id,
    output logic [mcab_pkg::ADDR_W-1:0]  o_buffer_addr,
    output logic [mcab_pkg::BYTES_W-1:0] o_placed_bytes,
    output logic                         o_overflow,
    output logic                         o_last
);
    localparam int AW = mcab_pkg::ADDR_W;
    localparam int CW = mcab_pkg::CHAN_W;
    localparam int NW = mcab_pkg::CCNT_W;

    typedef enum logic [1:0] {S_IDLE, S_ALIGN, S_TEST} t_state;

    t_state                       r_state;
    logic [CW-1:0]                r_chan;
    logic [AW-1:0]                r_next;
    logic [AW:0]                  r_aligned;
    logic [mcab_pkg::BYTES_W-1:0] r_bytes;
    logic [CELL_W-1:0]            r_cells;
    logic [CELL_W-1:0]            r_cell;

    logic [AW-1:0]                cur_limit, nxt_start;
    logic [CW-1:0]                chan_inc;
    logic [AW+1:0]                end_addr;
    logic                         fits, is_last_chan, is_last_cell;
    logic [NW-1:0]                ccnt;

    // effective channel count, clamped to 1..MAX_CHANNELS
    always_comb begin
        ccnt = i_cfg.channel_count;
        if (ccnt == '0) begin
            ccnt = NW'(1);
        end else if (ccnt > NW'(MAX_CHANNELS)) begin
            ccnt = NW'(MAX_CHANNELS);
        end
    end

    assign chan_inc = CW'(r_chan + 1'b1);

    always_comb begin
        cur_limit = '0;
        nxt_start = '0;
        for (int i = 0; i < MAX_CHANNELS; i++) begin
            if (r_chan == CW'(i)) begin
                cur_limit = i_win[i][AW-1:0];
            end
            if (chan_inc == CW'(i)) begin
                nxt_start = i_win[i][2*AW-1:AW];
            end
        end
    end

    assign end_addr     = {1'b0, r_aligned} + (AW+2)'(r_bytes);
    assign fits         = (end_addr <= (AW+2)'(cur_limit));
    assign is_last_chan = ((NW'(r_chan) + 1'b1) >= ccnt);
    assign is_last_cell = (CELL_W'(r_cell + 1'b1) == r_cells);
    assign o_pop        = (r_state == S_IDLE) && !i_q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_chan         <= '0;
            r_next         <= '0;
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_bytes <= i_q_bytes;
                        r_cells <= i_q_cells;
                        r_cell  <= '0;
                        r_state <= S_ALIGN;
                    end
                end
                S_ALIGN: begin
                    r_aligned <= mcab_pkg::align_addr(i_cfg.align_mode, r_next);
                    r_state   <= S_TEST;
                end
                S_TEST: begin
                    if (fits) begin
                        o_result_valid <= 1'b1;
                        o_channel_id   <= r_chan;
                        o_buffer_addr  <= r_aligned[AW-1:0];
                        o_placed_bytes <= r_bytes;
                        o_overflow     <= 1'b0;
                        o_last         <= is_last_cell;
                        r_next         <= end_addr[AW-1:0];
                        r_cell         <= CELL_W'(r_cell + 1'b1);
                        r_state        <= is_last_cell ? S_IDLE : S_ALIGN;
                    end else if (is_last_chan) begin
                        o_result_valid <= 1'b1;
                        o_channel_id   <= r_chan;
                        o_buffer_addr  <= '0;
                        o_placed_bytes <= '0;
                        o_overflow     <= 1'b1;
                        o_last         <= 1'b1;
                        r_state        <= S_IDLE;
                    end else begin
                        r_chan  <= chan_inc;
                        r_next  <= nxt_start;
                        r_state <= S_ALIGN;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> rtl/core/multi_channel_aligned_bump_allocator_unit.sv
// ----------------------------------------------------------------------------
// multi_channel_aligned_bump_allocator_unit
// Bump allocator over up to four memory channels with 64-byte or odd
// 32-byte alignment; one placement per grid cell, overflow on exhaustion.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                    Payload
//  --------  ---------  ---------------------------  --------------------------
//  request   in         start / busy                 i_buffer_bytes,
//                                                    i_grid_rows, i_grid_cols
//  result    out        o_result_valid (1-cycle)     o_channel_id, o_buffer_addr,
//                                                    o_placed_bytes, o_overflow,
//                                                    o_last
//  config    in/out     APB (psel/penable/pready)    paddr, pwdata, prdata
//
//  A request transaction is registered in the intake stage, then waits in a
//  two-entry queue. The placement engine picks up the request from idle, then
//  runs an align state, then a fit-test state, for each placed cell and again
//  after each channel skip.
//  busy rises only when the intake stage is full and the queue is full.
//  The receiver cannot stall: each result shows for exactly one cycle.
//  Reset is synchronous, active low; it clears control state and all
//  configuration registers (channel_count resets to 1), channel 0, address 0.
//
module multi_channel_aligned_bump_allocator_unit #(
    parameter int MAX_CHANNELS = mcab_pkg::MAX_CHANNELS,
    parameter int GRID_MAX     = mcab_pkg::GRID_MAX
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request transaction
    input  logic                          start,
    output logic                          busy,
    input  logic [mcab_pkg::BYTES_W-1:0]  i_buffer_bytes,
    input  logic [mcab_pkg::GRID_W-1:0]   i_grid_rows,
    input  logic [mcab_pkg::GRID_W-1:0]   i_grid_cols,
    // result transaction
    output logic                          o_result_valid,
    output logic [mcab_pkg::CHAN_W-1:0]   o_channel_id,
    output logic [mcab_pkg::ADDR_W-1:0]   o_buffer_addr,
    output logic [mcab_pkg::BYTES_W-1:0]  o_placed_bytes,
    output logic                          o_overflow,
    output logic                          o_last,
    // APB configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mcab_pkg::PADDR_W-1:0]  paddr,
    input  logic [mcab_pkg::PDATA_W-1:0]  pwdata,
    output logic [mcab_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    // cell count width: enough for GRID_MAX * GRID_MAX
    localparam int CELL_W = $clog2(GRID_MAX * GRID_MAX + 1);
    localparam int QW     = mcab_pkg::BYTES_W + CELL_W;

    // ---------------- configuration registers ----------------
    logic                          r_align_mode;
    logic [mcab_pkg::CCNT_W-1:0]   r_channel_count;
    logic [mcab_pkg::WIN_W-1:0]    r_win [MAX_CHANNELS];

    logic                          cfg_wr;
    logic [2:0]                    reg_idx;
    logic [2:0]                    win_idx;
    mcab_pkg::t_cfg                cfg;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[5:3];   // registers are 8 bytes apart
    assign win_idx = reg_idx - mcab_pkg::REG_REGION0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_align_mode    <= mcab_pkg::ALIGN_ODD32;
            r_channel_count <= mcab_pkg::CCNT_W'(1);
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                r_win[i] <= '0;
            end
        end else if (cfg_wr) begin
            if (reg_idx == mcab_pkg::REG_ALIGN_MODE) begin
                r_align_mode <= pwdata[0];
            end
            if (reg_idx == mcab_pkg::REG_CHANNEL_COUNT) begin
                r_channel_count <= pwdata[mcab_pkg::CCNT_W-1:0];
            end
            // window writes: out-of-range indexes are dropped
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                if (reg_idx >= mcab_pkg::REG_REGION0 && win_idx == 3'(i)) begin
                    r_win[i] <= pwdata;
                end
            end
        end
    end

    // read mux
    always_comb begin
        prdata = '0;
        if (reg_idx == mcab_pkg::REG_ALIGN_MODE) begin
            prdata = mcab_pkg::PDATA_W'(r_align_mode);
        end else if (reg_idx == mcab_pkg::REG_CHANNEL_COUNT) begin
            prdata = mcab_pkg::PDATA_W'(r_channel_count);
        end else begin
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                if (reg_idx >= mcab_pkg::REG_REGION0 && win_idx == 3'(i)) begin
                    prdata = r_win[i];
                end
            end
        end
    end

    assign cfg.align_mode    = r_align_mode;
    assign cfg.channel_count = r_channel_count;

    // ---------------- front: intake and classification ----------------
    logic                          q_push, q_full, q_pop, q_empty;
    logic [mcab_pkg::BYTES_W-1:0]  f_bytes;
    logic [CELL_W-1:0]             f_cells;
    logic [QW-1:0]                 q_rdata;

    mcab_front #(
        .GRID_MAX (GRID_MAX),
        .CELL_W   (CELL_W)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .o_busy         (busy),
        .i_buffer_bytes (i_buffer_bytes),
        .i_grid_rows    (i_grid_rows),
        .i_grid_cols    (i_grid_cols),
        .o_push         (q_push),
        .o_bytes        (f_bytes),
        .o_cells        (f_cells),
        .i_q_full       (q_full)
    );

    // ---------------- request queue ----------------
    mcab_queue #(
        .WIDTH (QW),
        .DEPTH (mcab_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  ({f_bytes, f_cells}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    // ---------------- back: placement engine ----------------
    mcab_back #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .CELL_W       (CELL_W)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_win          (r_win),
        .i_q_empty      (q_empty),
        .i_q_bytes      (q_rdata[QW-1:CELL_W]),
        .i_q_cells      (q_rdata[CELL_W-1:0]),
        .o_pop          (q_pop),
        .o_result_valid (o_result_valid),
        .o_channel_id   (o_channel_id),
        .o_buffer_addr  (o_buffer_addr),
        .o_placed_bytes (o_placed_bytes),
        .o_overflow     (o_overflow),
        .o_last         (o_last)
    );

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multi-channel aligned bump allocator. Requests
// are fed through start/busy from a queue. Each accepted transaction runs
// through a local placement predictor that tracks the channel, the bump
// pointer and the register shadows, and every result strobe is compared
// field by field against the oldest predicted placement.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Package constants used here
    localparam int         MAX_CHANNELS      = mcab_pkg::MAX_CHANNELS;
    localparam int         GRID_MAX          = mcab_pkg::GRID_MAX;
    localparam int         ADDR_W            = mcab_pkg::ADDR_W;
    localparam int         BYTES_W           = mcab_pkg::BYTES_W;
    localparam int         GRID_W            = mcab_pkg::GRID_W;
    localparam int         CHAN_W            = mcab_pkg::CHAN_W;
    localparam int         CCNT_W            = mcab_pkg::CCNT_W;
    localparam int         WIN_W             = mcab_pkg::WIN_W;
    localparam int         PADDR_W           = mcab_pkg::PADDR_W;
    localparam int         PDATA_W           = mcab_pkg::PDATA_W;
    localparam logic [2:0] REG_ALIGN_MODE    = mcab_pkg::REG_ALIGN_MODE;
    localparam logic [2:0] REG_CHANNEL_COUNT = mcab_pkg::REG_CHANNEL_COUNT;
    localparam logic [2:0] REG_REGION0       = mcab_pkg::REG_REGION0;
    localparam logic       ALIGN_ODD32       = mcab_pkg::ALIGN_ODD32;
    localparam logic       ALIGN_64          = mcab_pkg::ALIGN_64;

    // Register slots past the window registers; writes there must be dropped
    localparam logic [2:0] REG_SPARE0 = 3'd6;
    localparam logic [2:0] REG_SPARE1 = 3'd7;

    // Cycles to let zero-result requests drain out of the intake stage.
    localparam int SETTLE_CYCLES = 450;

    typedef struct {
        logic [BYTES_W-1:0] nbytes;
        logic [GRID_W-1:0]  rows;
        logic [GRID_W-1:0]  cols;
    } t_request;

    typedef struct {
        logic [CHAN_W-1:0]  chan;
        logic [ADDR_W-1:0]  addr;
        logic [BYTES_W-1:0] nbytes;
        logic               ovf;
        logic               last;
    } t_placement;

    // ------------------------------------------------------------------------
    // DUT hookup; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                 i_clk   = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start   = 1'b0;
    logic                 busy;
    logic [BYTES_W-1:0]   i_buffer_bytes = '0;
    logic [GRID_W-1:0]    i_grid_rows    = '0;
    logic [GRID_W-1:0]    i_grid_cols    = '0;
    logic                 o_result_valid;
    logic [CHAN_W-1:0]    o_channel_id;
    logic [ADDR_W-1:0]    o_buffer_addr;
    logic [BYTES_W-1:0]   o_placed_bytes;
    logic                 o_overflow;
    logic                 o_last;
    logic                 psel    = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite  = 1'b0;
    logic [PADDR_W-1:0]   paddr   = '0;
    logic [PDATA_W-1:0]   pwdata  = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    multi_channel_aligned_bump_allocator_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_buffer_bytes (i_buffer_bytes),
        .i_grid_rows    (i_grid_rows),
        .i_grid_cols    (i_grid_cols),
        .o_result_valid (o_result_valid),
        .o_channel_id   (o_channel_id),
        .o_buffer_addr  (o_buffer_addr),
        .o_placed_bytes (o_placed_bytes),
        .o_overflow     (o_overflow),
        .o_last         (o_last),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    t_request   requests_waiting[$];   // not yet offered to the block
    t_placement placements_due[$];     // predicted, not yet seen
    int         offered_cnt = 0;       // requests raised on start
    int         taken_cnt   = 0;       // requests accepted (start & !busy)
    int         idle_pct    = 37;      // driver gap probability, percent
    int         error_count = 0;

    // Register shadows, reset values
    logic                align_sel    = ALIGN_ODD32;
    logic [CCNT_W-1:0]   chan_cnt_cfg = CCNT_W'(1);
    logic [WIN_W-1:0]    chan_window [MAX_CHANNELS];

    // Allocator state: channel in use and bump pointer
    logic [CHAN_W-1:0]   chan_now = '0;
    logic [ADDR_W-1:0]   bump_ptr = '0;

    initial begin
        foreach (chan_window[c]) chan_window[c] = '0;
    end

    // ------------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------------
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Hard stop in case the block hangs
    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Placement predictor
    // ------------------------------------------------------------------------
    // Bump pointer rounded up under the current mode; 33 bits so a pointer
    // near the top of the space rounds past 4 GiB instead of wrapping.
    function automatic logic [ADDR_W:0] round_up_addr(input logic [ADDR_W-1:0] a);
        logic [ADDR_W:0] r;
        if (align_sel == ALIGN_64) begin
            r = ({1'b0, a} + 33'd63) & ~33'd63;
        end else begin
            // odd multiple of 32: bump by 32 when we land on a 64B boundary
            r = ({1'b0, a} + 33'd31) & ~33'd31;
            if (!r[5]) r = r + 33'd32;
        end
        return r;
    endfunction

    // Walk the grid cell by cell, skipping channels on misfit, and queue the
    // placements the block should emit for this transaction.
    function automatic void place_request(input logic [BYTES_W-1:0] nbytes,
                                          input logic [GRID_W-1:0] rows_in,
                                          input logic [GRID_W-1:0] cols_in);
        int unsigned     rows;
        int unsigned     cols;
        int unsigned     cells;
        int unsigned     idx;
        int              lim;
        logic [CHAN_W-1:0] ch;
        logic [ADDR_W:0]   aligned;
        logic [ADDR_W+1:0] buf_end;
        bit              placed;
        bit              dropped;
        t_placement      p;

        rows  = (rows_in > GRID_MAX) ? GRID_MAX : rows_in;
        cols  = (cols_in > GRID_MAX) ? GRID_MAX : cols_in;
        cells = rows * cols;
        // channel count clamps into 1..MAX_CHANNELS
        lim = int'(chan_cnt_cfg);
        if (lim < 1) lim = 1;
        if (lim > MAX_CHANNELS) lim = MAX_CHANNELS;

        dropped = 1'b0;
        idx = 0;
        while (idx < cells && !dropped) begin
            placed = 1'b0;
            while (!placed && !dropped) begin
                ch      = chan_now;
                aligned = round_up_addr(bump_ptr);
                buf_end = {1'b0, aligned} + {2'b0, nbytes};
                if (buf_end > {2'b0, chan_window[ch][ADDR_W-1:0]}) begin
                    // a channel past the enabled ones counts as the last one
                    if (int'(ch) >= lim - 1) begin
                        p = '{chan: ch, addr: '0, nbytes: '0, ovf: 1'b1, last: 1'b1};
                        placements_due = {placements_due, p};
                        dropped = 1'b1;
                    end else begin
                        chan_now = ch + CHAN_W'(1);
                        bump_ptr = chan_window[chan_now][WIN_W-1:ADDR_W];
                    end
                end else begin
                    p = '{chan: ch, addr: aligned[ADDR_W-1:0], nbytes: nbytes,
                          ovf: 1'b0, last: (idx == cells - 1)};
                    placements_due = {placements_due, p};
                    bump_ptr = buf_end[ADDR_W-1:0];
                    placed   = 1'b1;
                end
            end
            idx++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Driver: one request transaction at a time, random gaps between them
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_request nxt;
        if (i_rst_n) begin
            // hold start until the block takes the transaction
            if (!start || taken_cnt == offered_cnt) begin
                if (requests_waiting.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                    nxt = requests_waiting.pop_front();
                    i_buffer_bytes <= nxt.nbytes;
                    i_grid_rows    <= nxt.rows;
                    i_grid_cols    <= nxt.cols;
                    start          <= 1'b1;
                    offered_cnt    <= offered_cnt + 1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: predict on acceptance, check every result strobe
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_placement want;
        if (i_rst_n) begin
            if (start && !busy) begin
                place_request(i_buffer_bytes, i_grid_rows, i_grid_cols);
                taken_cnt <= taken_cnt + 1;
            end
            if (o_result_valid) begin
                if (placements_due.size() == 0) begin
                    $error("result with no placement pending: chan %0d addr %h",
                           o_channel_id, o_buffer_addr);
                    error_count++;
                end else begin
                    want = placements_due.pop_front();
                    if (o_channel_id !== want.chan) begin
                        $error("channel_id: expected %0d, got %0d", want.chan, o_channel_id);
                        error_count++;
                    end
                    if (o_buffer_addr !== want.addr) begin
                        $error("buffer_addr: expected %h, got %h", want.addr, o_buffer_addr);
                        error_count++;
                    end
                    if (o_placed_bytes !== want.nbytes) begin
                        $error("placed_bytes: expected %h, got %h", want.nbytes,
                               o_placed_bytes);
                        error_count++;
                    end
                    if (o_overflow !== want.ovf) begin
                        $error("overflow: expected %0d, got %0d", want.ovf, o_overflow);
                        error_count++;
                    end
                    if (o_last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, o_last);
                        error_count++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic issue_request(input logic [BYTES_W-1:0] nbytes,
                                 input logic [GRID_W-1:0] rows,
                                 input logic [GRID_W-1:0] cols);
        t_request r;
        r = '{nbytes: nbytes, rows: rows, cols: cols};
        requests_waiting = {requests_waiting, r};
    endtask

    // Mostly small well-formed grids; the rest is full-range noise
    task automatic queue_random_request();
        logic [BYTES_W-1:0] nb;
        logic [GRID_W-1:0]  r;
        logic [GRID_W-1:0]  cl;
        if ($urandom_range(0, 99) < 75) begin
            nb = BYTES_W'($urandom_range(0, 32'h1000));
            if ($urandom_range(0, 9) == 0) begin
                r  = GRID_W'($urandom_range(8, 15));
                cl = GRID_W'($urandom_range(1, 15));
            end else begin
                r  = GRID_W'($urandom_range(1, 4));
                cl = GRID_W'($urandom_range(1, 4));
            end
        end else begin
            nb = BYTES_W'($urandom());
            r  = GRID_W'($urandom_range(0, 15));
            cl = GRID_W'($urandom_range(0, 15));
        end
        issue_request(nb, r, cl);
    endtask

    // Everything offered, taken and checked, then let empty grids drain
    task automatic settle_block();
        while (requests_waiting.size() != 0 || taken_cnt != offered_cnt ||
               placements_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write: setup, access, then shadow update at the write edge
    task automatic cfg_write(input logic [2:0] idx, input logic [PDATA_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (idx == REG_ALIGN_MODE) begin
            align_sel = value[0];
        end else if (idx == REG_CHANNEL_COUNT) begin
            chan_cnt_cfg = value[CCNT_W-1:0];
        end else if (int'(idx) >= int'(REG_REGION0) &&
                     int'(idx) < int'(REG_REGION0) + MAX_CHANNELS) begin
            chan_window[int'(idx) - int'(REG_REGION0)] = value;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [ADDR_W:0]   fit_addr;
        logic [ADDR_W-1:0] w_start;
        logic [ADDR_W-1:0] w_limit;
        logic [CCNT_W-1:0] cnt_pick;
        int                p;
        int                c;
        int                k;

        @(posedge i_rst_n);
        repeat (2) @(posedge i_clk);

        // Reset config: empty channel 0, so the first cell overflows
        issue_request('0, 4'd1, 4'd1);
        issue_request(32'd5, 4'd0, 4'd5);       // no rows
        issue_request(32'd5, 4'd3, 4'd0);       // no columns
        settle_block();

        // Writes to slots beyond the map must not disturb anything
        cfg_write(REG_SPARE0, {$urandom(), $urandom()});
        cfg_write(REG_SPARE1, {$urandom(), $urandom()});

        // Channel 0 spans almost all of the address space, 64B alignment
        cfg_write(REG_ALIGN_MODE, PDATA_W'(ALIGN_64));
        cfg_write(REG_CHANNEL_COUNT, PDATA_W'(1));
        cfg_write(REG_REGION0, {32'h0000_0000, 32'hFFFF_FFE1});
        issue_request(32'd100, 4'd2, 4'd2);
        issue_request(32'hFFFF_FFFF, 4'd1, 4'd1);   // never fits
        issue_request(32'h0000_0100, 4'd15, 4'd15); // oversized grid, clamps to 8x8
        issue_request('0, 4'd9, 4'd1);              // zero-size buffers
        settle_block();

        // Buffer ending exactly on the limit, then the pointer rounds past 4 GiB
        fit_addr = round_up_addr(bump_ptr);
        issue_request(32'hFFFF_FFE1 - fit_addr[ADDR_W-1:0], 4'd1, 4'd1);
        issue_request('0, 4'd1, 4'd1);
        settle_block();
        cfg_write(REG_ALIGN_MODE, PDATA_W'(ALIGN_ODD32));
        issue_request('0, 4'd1, 4'd1);
        settle_block();

        // Count of zero acts as one channel
        cfg_write(REG_CHANNEL_COUNT, PDATA_W'(0));
        issue_request('0, 4'd1, 4'd1);
        settle_block();

        // Count above the maximum acts as four; spill into channel 1
        cfg_write(REG_CHANNEL_COUNT, PDATA_W'(7));
        cfg_write(REG_REGION0 + 3'd1, {32'h0000_1000, 32'h0000_1FFF});
        issue_request(32'h20, 4'd1, 4'd1);
        issue_request(32'h1F, 4'd3, 4'd2);
        settle_block();

        // Lower the count under the channel in use: it acts as the last one
        cfg_write(REG_CHANNEL_COUNT, PDATA_W'(1));
        issue_request(32'h40, 4'd2, 4'd1);
        issue_request(32'h1000, 4'd1, 4'd1);
        settle_block();

        // Random phases: fresh windows ahead of the current channel, the
        // current one stretched past the pointer so placements keep going.
        for (p = 0; p < 6; p++) begin
            settle_block();
            case (p)
                0:       cnt_pick = CCNT_W'(4);
                2:       cnt_pick = CCNT_W'(7);
                3:       cnt_pick = CCNT_W'(1);
                5:       cnt_pick = CCNT_W'(4);
                default: cnt_pick = CCNT_W'($urandom_range(0, 7));
            endcase
            cfg_write(REG_ALIGN_MODE, PDATA_W'(p % 2));
            cfg_write(REG_CHANNEL_COUNT, PDATA_W'(cnt_pick));
            for (c = 0; c < MAX_CHANNELS; c++) begin
                if (c < int'(chan_now)) begin
                    // left behind, never read again
                    cfg_write(REG_REGION0 + 3'(c), {$urandom(), $urandom()});
                end else if (c == int'(chan_now)) begin
                    w_start = ADDR_W'($urandom_range(0, 32'h3FFF_FFFF));
                    w_limit = bump_ptr + ADDR_W'($urandom_range(32'h800, 32'h1_0000));
                    cfg_write(REG_REGION0 + 3'(c), {w_start, w_limit});
                end else begin
                    w_start = ADDR_W'($urandom_range(0, 32'h3FFF_FFFF));
                    if ($urandom_range(0, 4) == 0)
                        w_limit = ADDR_W'($urandom_range(0, w_start));  // tiny or inverted
                    else
                        w_limit = w_start + ADDR_W'($urandom_range(0, 32'h8000));
                    cfg_write(REG_REGION0 + 3'(c), {w_start, w_limit});
                end
            end
            idle_pct = (p == 2) ? 0 : 37;   // one phase back to back
            for (k = 0; k < 20; k++)
                queue_random_request();
        end

        settle_block();
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
